[design/trie_insert_lookup_defines.svh]
// Assertion helpers for the trie design, used by trie_insert_lookup.sv.
// Each expects signals named clk and rst_n in the calling scope.
`ifndef TRIE_INSERT_LOOKUP_DEFINES_SVH
`define TRIE_INSERT_LOOKUP_DEFINES_SVH

// Same-cycle implication
`define TIL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/til_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package til_pkg;

    // Width of the symbol field on the request channel
    localparam int SYMBOL_W = 8;

    // Default pool size and symbol alphabet
    localparam int NODE_COUNT_DEF  = 1024;
    localparam int SYMBOL_BITS_DEF = 8;

endpackage

`default_nettype wire

[design/til_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one symbol of a string per item
interface til_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [til_pkg::SYMBOL_W-1:0] symbol;
    logic                         last;

    modport source (output valid, command, symbol, last, input ready);
    modport sink   (input valid, command, symbol, last, output ready);
endinterface

`default_nettype wire

[design/til_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one item per finished string
interface til_out_if;
    logic valid;
    logic ready;
    logic found;
    logic overflow;

    modport source (output valid, found, overflow, input ready);
    modport sink   (input valid, found, overflow, output ready);
endinterface

`default_nettype wire

[design/til_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module til_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/trie_insert_lookup.sv]
// trie_insert_lookup: a set of byte strings kept as a trie.
//
// request carries one symbol per item (command 0 = insert, 1 = query, last
// marks the final symbol). result carries one item per string, on its last
// symbol: found (query hit) and overflow (node pool ran out during the walk).
// Items are taken with valid/ready on both channels.
//
// Each symbol costs one child-table read (a registered RAM read, issued as
// the symbol is taken) and a step in S_LOOK to decide and write back; the
// block takes no new symbol until it is back in S_IDLE. A last insert symbol
// loads the result register in S_LOOK; a last query symbol first reads the
// terminal mark of the node reached and loads the result from S_TERM.
// The result sits in an output register; the block takes further symbols
// while it waits. It stalls only when a new result is due and the previous
// one has not been taken.
//
// After reset the block sweeps both memories to zero, one child entry a
// cycle over all NODE_COUNT << SYMBOL_BITS entries (262144 by default).
// request.ready stays low until the sweep is done.
`timescale 1ns / 1ps
`default_nettype none

`include "trie_insert_lookup_defines.svh"

module trie_insert_lookup #(
    parameter int NODE_COUNT  = til_pkg::NODE_COUNT_DEF,
    parameter int SYMBOL_BITS = til_pkg::SYMBOL_BITS_DEF
) (
    input wire logic      clk,
    input wire logic      rst_n,
    til_in_if.sink        request,
    til_out_if.source     result
);

    localparam int NODE_BITS   = $clog2(NODE_COUNT);
    localparam int USED_W      = NODE_BITS + 1;
    localparam int ADDR_BITS   = NODE_BITS + SYMBOL_BITS;
    localparam int CHILD_DEPTH = NODE_COUNT << SYMBOL_BITS;

    localparam logic [ADDR_BITS-1:0] CLR_LAST   = ADDR_BITS'(CHILD_DEPTH - 1);
    localparam logic [USED_W-1:0]    USED_LIMIT = USED_W'(NODE_COUNT);

    // Sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_TERM  = 2'd3;

    // Control state
    logic [1:0]           state_reg,    state_next;
    logic [ADDR_BITS-1:0] clr_reg,      clr_next;
    logic [NODE_BITS-1:0] node_reg,     node_next;
    logic                 miss_reg,     miss_next;
    logic                 ovf_reg,      ovf_next;
    logic [USED_W-1:0]    used_reg,     used_next;
    logic                 out_vld_reg,  out_vld_next;

    // Payload registers
    logic                 cmd_reg;
    logic                 last_reg;
    logic [ADDR_BITS-1:0] slot_reg;
    logic                 found_reg,    found_next;
    logic                 oflow_reg,    oflow_next;

    // Memory ports
    logic                 child_we;
    logic [ADDR_BITS-1:0] child_waddr;
    logic [NODE_BITS-1:0] child_wdata;
    logic                 child_re;
    logic [ADDR_BITS-1:0] child_raddr;
    logic [NODE_BITS-1:0] child_rdata;
    logic                 term_we;
    logic [NODE_BITS-1:0] term_waddr;
    logic [0:0]           term_wdata;
    logic                 term_re;
    logic [0:0]           term_rdata;

    // Walk step
    logic                 walking;
    logic                 alloc;
    logic                 commit;
    logic                 out_free;
    logic                 out_load;
    logic                 accept;
    logic [NODE_BITS-1:0] step_node;
    logic                 step_miss;
    logic                 step_ovf;

    til_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (CHILD_DEPTH)
    ) u_child_ram (
        .clk     (clk),
        .wr_en   (child_we),
        .wr_addr (child_waddr),
        .wr_data (child_wdata),
        .rd_en   (child_re),
        .rd_addr (child_raddr),
        .rd_data (child_rdata)
    );

    til_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_term_ram (
        .clk     (clk),
        .wr_en   (term_we),
        .wr_addr (term_waddr),
        .wr_data (term_wdata),
        .rd_en   (term_re),
        .rd_addr (term_waddr),
        .rd_data (term_rdata)
    );

    // Handshakes
    assign request.ready   = (state_reg == S_IDLE);
    assign accept          = request.valid && request.ready;
    assign out_free        = !out_vld_reg || result.ready;
    assign result.valid    = out_vld_reg;
    assign result.found    = found_reg;
    assign result.overflow = oflow_reg;

    // Child lookup is issued as the item is taken
    assign child_re    = accept;
    assign child_raddr = {node_reg, request.symbol[SYMBOL_BITS-1:0]};

    // One step of the walk from the child entry just read
    always_comb
    begin
        walking   = !miss_reg && !ovf_reg;
        alloc     = 1'b0;
        step_node = node_reg;
        step_miss = miss_reg;
        step_ovf  = ovf_reg;
        if (walking)
        begin
            if (child_rdata != '0)
            begin
                step_node = child_rdata;
            end
            else if (cmd_reg)
            begin
                step_miss = 1'b1;
            end
            else if (used_reg < USED_LIMIT)
            begin
                alloc     = 1'b1;
                step_node = used_reg[NODE_BITS-1:0];
            end
            else
            begin
                step_ovf = 1'b1;
            end
        end
    end

    // A last insert finishes in S_LOOK and needs the result slot
    assign commit = (state_reg == S_LOOK) && (!last_reg || cmd_reg || out_free);

    // Sequencer and memory writes.
    // A child write lands in S_LOOK, before the next read can be issued from
    // S_IDLE, so that read always sees it; no forwarding is needed.
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        node_next    = node_reg;
        miss_next    = miss_reg;
        ovf_next     = ovf_reg;
        used_next    = used_reg;
        out_vld_next = out_vld_reg && !result.ready;
        found_next   = found_reg;
        oflow_next   = oflow_reg;
        out_load     = 1'b0;
        child_we     = 1'b0;
        child_waddr  = slot_reg;
        child_wdata  = step_node;
        term_we      = 1'b0;
        term_waddr   = step_node;
        term_wdata   = 1'b1;
        term_re      = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                child_we    = 1'b1;
                child_waddr = clr_reg;
                child_wdata = '0;
                term_we     = 1'b1;
                term_waddr  = clr_reg[ADDR_BITS-1:SYMBOL_BITS];
                term_wdata  = 1'b0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (commit)
                begin
                    child_we  = alloc;
                    used_next = alloc ? used_reg + 1'b1 : used_reg;
                    node_next = step_node;
                    miss_next = step_miss;
                    ovf_next  = step_ovf;
                    if (!last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (cmd_reg)
                    begin
                        // query end: read the terminal mark of the node reached
                        term_re    = 1'b1;
                        state_next = S_TERM;
                    end
                    else
                    begin
                        // insert end: mark the node unless the walk broke off
                        term_we    = !step_miss && !step_ovf;
                        out_load   = 1'b1;
                        found_next = 1'b0;
                        oflow_next = step_ovf;
                        state_next = S_IDLE;
                    end
                end
            end
            S_TERM:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    found_next = !miss_reg && !ovf_reg && term_rdata[0];
                    oflow_next = ovf_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // String done: walk returns to the root
        if (out_load)
        begin
            out_vld_next = 1'b1;
            node_next    = '0;
            miss_next    = 1'b0;
            ovf_next     = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            node_reg    <= '0;
            miss_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            used_reg    <= USED_W'(1);
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            node_reg    <= node_next;
            miss_reg    <= miss_next;
            ovf_reg     <= ovf_next;
            used_reg    <= used_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= request.command;
            last_reg <= request.last;
            slot_reg <= child_raddr;
        end
        found_reg <= found_next;
        oflow_reg <= oflow_next;
    end

    // Checks
    `TIL_ASSERT_NOW(a_pool_bound, 1'b1, used_reg <= USED_LIMIT, "node count beyond pool")
    `TIL_ASSERT_NOW(a_alloc_room, child_we && state_reg != S_CLEAR, used_reg < USED_LIMIT,
        "node allocated from a full pool")
    `TIL_ASSERT_NOW(a_no_take_clear, state_reg == S_CLEAR, !request.ready,
        "item taken during the clearing sweep")
    `TIL_ASSERT_NEXT(a_root_after_end, out_load,
        node_reg == '0 && !miss_reg && !ovf_reg, "walk not back at root after a string")
    `TIL_ASSERT_NOW(a_result_on_last, $rose(out_vld_reg), $past(last_reg),
        "result raised without a last symbol")

endmodule

`default_nettype wire

[tb/trie_insert_lookup_test.sv]
`timescale 1ns / 1ps

module trie_insert_lookup_test;
    import til_pkg::*;

    localparam int NODES       = NODE_COUNT_DEF;
    localparam int SYM_BITS    = SYMBOL_BITS_DEF;
    localparam int SYMS        = 1 << SYM_BITS;
    localparam int ITEM_TARGET = 1450;
    localparam int MIXED_LIMIT = 450;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 40;
    localparam int DRAIN_WAIT  = 20;

    typedef enum logic {CMD_INSERT = 1'b0, CMD_QUERY = 1'b1} cmd_t;
    typedef logic [SYMBOL_W-1:0] sym_t;
    typedef sym_t sym_q_t[$];

    typedef struct packed {
        cmd_t command;
        sym_t symbol;
        logic last;
    } sym_item_t;

    typedef struct packed {
        logic found;
        logic overflow;
    } string_result_t;

    localparam sym_t SYM_MASK = sym_t'(SYMS - 1);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    til_in_if  request ();
    til_out_if result ();

    trie_insert_lookup u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result)
    );

    // Driven copies of the channel inputs, known from time zero
    logic      drv_valid = 1'b0;
    sym_item_t drv_item  = '0;
    logic      rsp_ready = 1'b0;

    assign request.valid   = drv_valid;
    assign request.command = drv_item.command;
    assign request.symbol  = drv_item.symbol;
    assign request.last    = drv_item.last;
    assign result.ready    = rsp_ready;

    always #6 clk = ~clk;

    sym_item_t      pending_items[$];
    string_result_t expected_results[$];
    int unsigned    items_planned = 0;
    int unsigned    error_count   = 0;
    int unsigned    results_seen  = 0;

    // Shadow trie: child links, terminal marks, pool and walk state
    bit [9:0]    trie_child [NODES*SYMS];
    bit          trie_term  [NODES];
    int unsigned pool_used = 1;
    bit [9:0]    walk_node = '0;
    bit          walk_missed = 1'b0;
    bit          walk_overflowed = 1'b0;

    // Advance the walk by one symbol; returns 1 when the string ends
    function automatic bit track_symbol(input sym_item_t it, output string_result_t res);
        int unsigned slot;
        bit [9:0]    nxt;
        res = '0;
        if (!walk_missed && !walk_overflowed) begin
            slot = (int'(walk_node) << SYM_BITS) | int'(it.symbol & SYM_MASK);
            nxt  = trie_child[slot];
            if (nxt != '0) begin
                walk_node = nxt;
            end else if (it.command == CMD_QUERY) begin
                walk_missed = 1'b1;
            end else if (pool_used < NODES) begin
                trie_child[slot] = 10'(pool_used);
                walk_node        = 10'(pool_used);
                pool_used++;
            end else begin
                walk_overflowed = 1'b1;
            end
        end
        if (!it.last)
            return 1'b0;
        if (it.command == CMD_QUERY) begin
            res.found = !walk_missed && !walk_overflowed && trie_term[walk_node];
        end else if (!walk_missed && !walk_overflowed) begin
            trie_term[walk_node] = 1'b1;
        end
        res.overflow    = walk_overflowed;
        walk_node       = '0;
        walk_missed     = 1'b0;
        walk_overflowed = 1'b0;
        return 1'b1;
    endfunction

    // Sender: bursts of random length separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : feed_requests
        string_result_t res;
        sym_item_t      taken;
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_item  <= '0;
        end
        else
        begin
            if (drv_valid && request.ready)
            begin
                taken = pending_items.pop_front();
                if (track_symbol(taken, res))
                    expected_results.push_back(res);
            end
            if (!drv_valid || request.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    drv_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    drv_valid <= 1'b1;
                    drv_item  <= pending_items[0];
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                               : $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: patterned stalls, plus one long hold-off to back up the block
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned stall_tick = 0;
    logic [15:0] stall_mask = '0;

    always @(posedge clk or negedge rst_n)
    begin : check_results
        string_result_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (result.valid && rsp_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: found=%0b overflow=%0b",
                           result.found, result.overflow);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.found !== want.found)
                    begin
                        $error("found: expected %0b, actual %0b", want.found, result.found);
                        error_count++;
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, result.overflow);
                        error_count++;
                    end
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                rsp_ready <= 1'b0;
            end
            else
            begin
                stall_tick++;
                if (stall_tick % 32 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       stall_mask = '0;
                        1:       stall_mask = 16'($urandom()) & 16'($urandom());
                        default: stall_mask = 16'($urandom());
                    endcase
                end
                rsp_ready <= !stall_mask[stall_tick % 16];
            end
        end
    end

    // Stimulus helpers
    sym_t        dict_syms[$];
    int unsigned dict_start[$];
    int unsigned dict_len[$];

    task automatic push_item(input cmd_t cmd, input sym_t sym, input logic last);
        sym_item_t it;
        it.command = cmd;
        it.symbol  = sym;
        it.last    = last;
        pending_items.push_back(it);
        items_planned++;
    endtask

    function automatic sym_t pick_symbol(input bit full_range);
        sym_t narrow[4];
        narrow = '{8'h00, 8'h5A, 8'hA5, 8'hFF};
        if (full_range || $urandom_range(0, 1) == 0)
            return sym_t'($urandom_range(0, 255));
        return narrow[$urandom_range(0, 3)];
    endfunction

    function automatic sym_q_t random_string(input int unsigned lo, input int unsigned hi,
                                             input bit full_range);
        sym_q_t      s;
        int unsigned n;
        n = $urandom_range(lo, hi);
        for (int unsigned i = 0; i < n; i++)
            s.push_back(pick_symbol(full_range));
        return s;
    endfunction

    function automatic sym_q_t known_string();
        sym_q_t      s;
        int unsigned k;
        k = $urandom_range(0, dict_len.size() - 1);
        for (int unsigned i = 0; i < dict_len[k]; i++)
            s.push_back(dict_syms[dict_start[k] + i]);
        return s;
    endfunction

    // mixed: each symbol gets a random command
    task automatic emit_string(input sym_q_t s, input cmd_t cmd, input bit mixed);
        for (int unsigned i = 0; i < s.size(); i++)
            push_item(mixed ? cmd_t'($urandom_range(0, 1)) : cmd, s[i], i == s.size() - 1);
    endtask

    task automatic remember(input sym_q_t s);
        dict_start.push_back(dict_syms.size());
        dict_len.push_back(s.size());
        foreach (s[i])
            dict_syms.push_back(s[i]);
    endtask

    // One well-formed or noisy string drawn from a weighted mix
    task automatic emit_mixed_string();
        sym_q_t      s;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35 || dict_len.size() == 0)
        begin
            s = random_string(1, 6, 1'b0);
            emit_string(s, CMD_INSERT, 1'b0);
            remember(s);
        end
        else if (pick < 60)
        begin
            emit_string(known_string(), CMD_QUERY, 1'b0);
        end
        else if (pick < 70)
        begin
            s = known_string();
            if (s.size() > 1 && $urandom_range(0, 1) == 0)
                void'(s.pop_back());
            else
                s.push_back(pick_symbol(1'b0));
            emit_string(s, CMD_QUERY, 1'b0);
        end
        else if (pick < 80)
        begin
            emit_string(random_string(1, 6, 1'b0), CMD_QUERY, 1'b0);
        end
        else if (pick < 88)
        begin
            emit_string(known_string(), CMD_INSERT, 1'b0);
        end
        else if (pick < 95)
        begin
            emit_string(random_string(1, 6, 1'b0), CMD_INSERT, 1'b1);
        end
        else
        begin
            s = known_string();
            s = {s, random_string(1, 3, 1'b1)};
            emit_string(s, CMD_INSERT, 1'b0);
            remember(s);
        end
    endtask

    // Reset, directed strings, random mix, pool fill, random mix, drain
    initial
    begin
        int unsigned fill_rounds;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // query on an empty set
        push_item(CMD_QUERY, 8'h41, 1'b1);
        // single-symbol insert, then hit
        push_item(CMD_INSERT, 8'h00, 1'b1);
        push_item(CMD_QUERY, 8'h00, 1'b1);
        // extreme symbols
        push_item(CMD_INSERT, 8'hFF, 1'b0);
        push_item(CMD_INSERT, 8'h00, 1'b0);
        push_item(CMD_INSERT, 8'h80, 1'b1);
        push_item(CMD_QUERY, 8'hFF, 1'b0);
        push_item(CMD_QUERY, 8'h00, 1'b0);
        push_item(CMD_QUERY, 8'h80, 1'b1);
        // stored prefix without terminal mark
        push_item(CMD_QUERY, 8'hFF, 1'b0);
        push_item(CMD_QUERY, 8'h00, 1'b1);
        // miss in the middle, trailing symbol ignored
        push_item(CMD_QUERY, 8'hFF, 1'b0);
        push_item(CMD_QUERY, 8'h01, 1'b0);
        push_item(CMD_QUERY, 8'h80, 1'b1);
        // command changes inside a string
        push_item(CMD_INSERT, 8'h11, 1'b0);
        push_item(CMD_QUERY, 8'h22, 1'b1);
        push_item(CMD_QUERY, 8'hFF, 1'b0);
        push_item(CMD_INSERT, 8'h55, 1'b1);
        push_item(CMD_QUERY, 8'hFF, 1'b0);
        push_item(CMD_QUERY, 8'h55, 1'b1);
        // insert ending after a query miss stores nothing
        push_item(CMD_QUERY, 8'h33, 1'b0);
        push_item(CMD_INSERT, 8'h44, 1'b1);
        push_item(CMD_QUERY, 8'h33, 1'b0);
        push_item(CMD_QUERY, 8'h44, 1'b1);

        while (items_planned < MIXED_LIMIT)
            emit_mixed_string();

        // exhaust the node pool with long fresh strings
        fill_rounds = 0;
        while (pool_used < NODES && fill_rounds < 100)
        begin
            emit_string(random_string(20, 28, 1'b1), CMD_INSERT, 1'b0);
            emit_string(random_string(20, 28, 1'b1), CMD_INSERT, 1'b0);
            fill_rounds++;
            while (pending_items.size() != 0)
                @(negedge clk);
        end

        // full pool: overflowing inserts next to hits and re-inserts
        while (items_planned < ITEM_TARGET)
            emit_mixed_string();

        while (pending_items.size() != 0 || drv_valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: clearing sweep plus the slowest run, several times over
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
